### rtl/modular_exponentiation_macros.svh
// assertion macros shared by the rtl files
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, checked out of reset
`define MX_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mx_pkg.sv
`timescale 1ns / 1ps

package mx_pkg;

    // operand width of base, exponent, modulus and result
    localparam int WORD_WIDTH = 64;
    // bit counter width inside the modular multiplier
    localparam int CNT_W = $clog2(WORD_WIDTH);

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // exponentiation sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_STEP,
        S_MUL,
        S_SQR,
        S_FINISH
    } mx_state_t;

endpackage

### rtl/modular_exponentiation.sv
`timescale 1ns / 1ps

// modular exponentiation: power_result = base_value ** exponent mod modulus
// config channel: cfg_valid/cfg_ready carries the modulus word; always ready,
//   write it only while the block is idle. reset value of the modulus is 1.
// input channel: in_valid/in_ready carries base_value and exponent; one word
//   is taken at a time and in_ready stays low until its result is registered.
// output channel: out_valid/out_ready carries power_result, one per input.
// work: one shared shift-add modular multiplier does all the work; an item
//   costs 1 + n + k modular products, n the bit length of the exponent and
//   k its number of set bits. a modulus of 0 gives 0 without a product.
// stall: the result waits in the output register; a new word is taken as
//   soon as the result has been moved into it, even if still unread. a
//   further result holds the sequencer until the output register frees.
// reset: clears the sequencer and output valid, modulus back to 1.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  mx_pkg::word_t modulus,
    input  logic          in_valid,
    output logic          in_ready,
    input  mx_pkg::word_t base_value,
    input  mx_pkg::word_t exponent,
    output logic          out_valid,
    input  logic          out_ready,
    output mx_pkg::word_t power_result
);
    import mx_pkg::*;

    mx_state_t state_reg;
    mx_state_t state_next;
    word_t     modulus_reg;
    word_t     acc_reg;
    word_t     sq_reg;
    word_t     exp_reg;
    logic      out_valid_reg;
    word_t     out_data_reg;
    word_t     one_mod;
    logic      mm_start;
    word_t     mm_a;
    word_t     mm_b;
    logic      mm_busy;
    logic      mm_done;
    word_t     mm_result;
    logic      out_load;

    assign one_mod   = (modulus_reg == word_t'(1)) ? '0 : word_t'(1);
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // shared modular multiplier
    mx_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (mm_b),
        .m      (modulus_reg),
        .busy   (mm_busy),
        .done   (mm_done),
        .result (mm_result)
    );

    // sequencer next state and multiplier launch
    always_comb
    begin
        state_next = state_reg;
        mm_start   = 1'b0;
        mm_a       = sq_reg;
        mm_b       = sq_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mm_a = one_mod;
                mm_b = base_value;
                if (in_valid)
                begin
                    if (modulus_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (exp_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mm_a       = acc_reg;
                    mm_start   = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_MUL:
            begin
                if (mm_done)
                begin
                    mm_start   = 1'b1;
                    state_next = S_SQR;
                end
            end
            S_SQR:
            begin
                if (mm_done)
                begin
                    state_next = S_STEP;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= word_t'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= modulus;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            acc_reg <= (modulus_reg == '0) ? '0 : one_mod;
            exp_reg <= exponent;
        end
        if (state_reg == S_REDUCE && mm_done)
        begin
            sq_reg <= mm_result;
        end
        if (state_reg == S_MUL && mm_done)
        begin
            acc_reg <= mm_result;
        end
        if (state_reg == S_SQR && mm_done)
        begin
            sq_reg  <= mm_result;
            exp_reg <= {1'b0, exp_reg[WORD_WIDTH-1:1]};
        end
        if (out_load)
        begin
            out_data_reg <= acc_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

    `MX_ASSERT_IMPL(a_done_expected, mm_done,
        state_reg == S_REDUCE || state_reg == S_MUL || state_reg == S_SQR,
        "multiplier finished outside a multiply state")
    `MX_ASSERT_IMPL(a_mul_busy, state_reg == S_STEP || state_reg == S_FINISH, !mm_busy,
        "multiplier busy while sequencer not waiting")
    `MX_ASSERT_NEXT(a_finish_holds, state_reg == S_FINISH && out_valid_reg && !out_ready,
        state_reg == S_FINISH, "result dropped while output stalled")

endmodule

### rtl/mx_modmul.sv
`timescale 1ns / 1ps

`include "modular_exponentiation_macros.svh"

// (a * b) mod m by shift-add, one doubling or one addition per cycle
module mx_modmul (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mx_pkg::word_t a,
    input  mx_pkg::word_t b,
    input  mx_pkg::word_t m,
    output logic          busy,
    output logic          done,
    output mx_pkg::word_t result
);
    import mx_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic                phase_reg;
    cnt_t                cnt_reg;
    word_t               acc_reg;
    word_t               a_reg;
    word_t               b_reg;
    word_t               m_reg;
    word_t               acc_next;
    logic [WORD_WIDTH:0] sum;
    logic [WORD_WIDTH:0] diff;

    // shared modular adder: doubles acc in phase 0, adds a in phase 1
    always_comb
    begin
        sum  = {1'b0, acc_reg} + {1'b0, (phase_reg ? a_reg : acc_reg)};
        diff = sum - {1'b0, m_reg};
        if (sum >= {1'b0, m_reg})
        begin
            acc_next = diff[WORD_WIDTH-1:0];
        end
        else
        begin
            acc_next = sum[WORD_WIDTH-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            // done pulses once after the last addition phase
            done_reg <= busy_reg && !start && phase_reg &&
                        (cnt_reg == cnt_t'(WORD_WIDTH - 1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
                cnt_reg   <= '0;
            end
            else if (busy_reg)
            begin
                phase_reg <= ~phase_reg;
                if (phase_reg)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == cnt_t'(WORD_WIDTH - 1))
                    begin
                        busy_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // operands and accumulator
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
            m_reg   <= m;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                acc_reg <= acc_next;
            end
            else
            begin
                if (b_reg[WORD_WIDTH-1])
                begin
                    acc_reg <= acc_next;
                end
                b_reg <= {b_reg[WORD_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = acc_reg;

    `MX_ASSERT_IMPL(a_no_restart, start, !busy_reg, "modmul started while busy")
    `MX_ASSERT_NEXT(a_acc_reduced, busy_reg && !start, acc_reg < m_reg,
        "modmul accumulator not reduced")
    `MX_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "modmul done held too long")

endmodule
